/* hdl/tlb_pkg.sv */
// Package for the TLB page translation unit: sizes, codes and shared types.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package tlb_pkg;
	localparam int TlbEntries = 8;
	localparam int NumProcs = 4;
	localparam int MaxVpnWidth = 8;
	localparam int MaxPfnWidth = 8;
	localparam int MaxOffsetWidth = 8;
	localparam int SlotW = $clog2(TlbEntries);
	localparam int PidW = 2;
	localparam int PtDepth = NumProcs * (1 << MaxVpnWidth);
	localparam int PtAw = $clog2(PtDepth);

	localparam logic [2:0] ModeTranslate = 3'd0;
	localparam logic [2:0] ModeMap = 3'd1;
	localparam logic [2:0] ModeUnmap = 3'd2;
	localparam logic [2:0] ModePtRead = 3'd3;
	localparam logic [2:0] ModeTlbRead = 3'd4;

	localparam logic [1:0] StatDone = 2'd0;
	localparam logic [1:0] StatPtHit = 2'd1;
	localparam logic [1:0] StatFault = 2'd2;

	localparam logic [1:0] RegOffset = 2'd0;
	localparam logic [1:0] RegVpn = 2'd1;
	localparam logic [1:0] RegLru = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic execute;
		logic clear_step;
	} tlb_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
	} tlb_stat_t;
endpackage

/* hdl/tlb_page_translation_unit.sv */
// TLB page translation unit: one word in, one result word out.
// The word is captured with its page table memory read, then the TLB update and
// result word are registered in the execute state; a new word waits for both.
// After reset a clearing pass writes all 1024 page table entries invalid;
// no input word is taken until it ends. Registers reset to 4, 4 and FIFO.
`timescale 1ns / 1ps
module tlb_page_translation_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [1:0]  pid,
	input  logic [15:0] vaddr,
	input  logic [7:0]  vpn,
	input  logic [7:0]  pfn,
	input  logic [2:0]  tlb_slot,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] phys_addr,
	output logic [2:0]  hit_slot,
	output logic        entry_valid,
	output logic [7:0]  entry_vpn,
	output logic [7:0]  entry_pfn,
	output logic [1:0]  entry_pid,
	output logic [31:0] entry_time
);
	logic [3:0] offset_bits_q, page_bits_q;
	logic       lru_q;
	tlb_pkg::tlb_cmd_t  cmd;
	tlb_pkg::tlb_stat_t stat;

	assign pready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= 4'd4;
			page_bits_q <= 4'd4;
			lru_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				tlb_pkg::RegOffset: offset_bits_q <= pwdata[3:0];
				tlb_pkg::RegVpn: page_bits_q <= pwdata[3:0];
				tlb_pkg::RegLru: lru_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		case (paddr[3:2])
			tlb_pkg::RegOffset: prdata = {28'd0, offset_bits_q};
			tlb_pkg::RegVpn: prdata = {28'd0, page_bits_q};
			tlb_pkg::RegLru: prdata = {31'd0, lru_q};
			default: prdata = '0;
		endcase
	end

	tlb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .stat(stat)
	);

	tlb_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.offset_bits(offset_bits_q), .page_bits(page_bits_q), .lru_mode(lru_q),
		.mode(mode), .pid(pid), .vaddr(vaddr), .vpn(vpn), .pfn(pfn),
		.tlb_slot(tlb_slot), .status(status), .phys_addr(phys_addr),
		.hit_slot(hit_slot), .entry_valid(entry_valid), .entry_vpn(entry_vpn),
		.entry_pfn(entry_pfn), .entry_pid(entry_pid), .entry_time(entry_time)
	);
endmodule

/* hdl/tlb_ctrl.sv */
// Controller of the TLB unit: clearing pass, capture, execute and output word.
// Depends on tlb_pkg.
`timescale 1ns / 1ps
module tlb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output tlb_pkg::tlb_cmd_t  cmd,
	input  tlb_pkg::tlb_stat_t stat
);
	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC} state_t;
	state_t state_q;
	logic   out_valid_q;

	// An input word is taken when idle and the output slot is free or leaving.
	assign in_stall = !(state_q == ST_IDLE && (!out_valid_q || !out_stall));
	assign out_valid = out_valid_q;
	assign cmd.capture = in_valid && !in_stall;
	assign cmd.execute = state_q == ST_EXEC;
	assign cmd.clear_step = state_q == ST_CLEAR;

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					if (stat.clear_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd.capture) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

/* hdl/tlb_dp.sv */
// Datapath of the TLB unit: TLB entries, page table memory, tick counter.
// Depends on tlb_pkg.
`timescale 1ns / 1ps
module tlb_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tlb_pkg::tlb_cmd_t         cmd,
	output tlb_pkg::tlb_stat_t        stat,
	input  logic [3:0]                offset_bits,
	input  logic [3:0]                page_bits,
	input  logic                      lru_mode,
	input  logic [2:0]                mode,
	input  logic [1:0]                pid,
	input  logic [15:0]               vaddr,
	input  logic [7:0]                vpn,
	input  logic [7:0]                pfn,
	input  logic [2:0]                tlb_slot,
	output logic [1:0]                status,
	output logic [15:0]               phys_addr,
	output logic [2:0]                hit_slot,
	output logic                      entry_valid,
	output logic [7:0]                entry_vpn,
	output logic [7:0]                entry_pfn,
	output logic [1:0]                entry_pid,
	output logic [31:0]               entry_time
);
	localparam int SW = tlb_pkg::SlotW;
	localparam int AW = tlb_pkg::PtAw;

	// TLB entries.
	logic [tlb_pkg::TlbEntries-1:0] valid_q;
	logic [7:0]  tag_q   [tlb_pkg::TlbEntries];
	logic [7:0]  frame_q [tlb_pkg::TlbEntries];
	logic [1:0]  owner_q [tlb_pkg::TlbEntries];
	logic [31:0] stamp_q [tlb_pkg::TlbEntries];
	logic [31:0] tick_q;

	// Page table memory with registered read.
	logic [8:0] pt_mem [tlb_pkg::PtDepth];
	logic [8:0] pt_rd_q;
	logic [AW-1:0] clr_q;

	// Captured word.
	logic [2:0]  mode_q;
	logic [1:0]  pid_q;
	logic [7:0]  pfn_q, vpn_q;
	logic [7:0]  ofs_q;
	logic [2:0]  slot_q;
	logic [3:0]  off_q;
	logic        range_bad_q;

	logic [3:0]  off_eff, vb_eff;
	logic [15:0] tv_full;
	logic [7:0]  sel_vpn;
	logic        bad_range;
	logic [AW-1:0] rd_addr;

	always_comb begin
		off_eff = (offset_bits > 4'(tlb_pkg::MaxOffsetWidth)) ?
			4'(tlb_pkg::MaxOffsetWidth) : offset_bits;
		vb_eff = page_bits;
		if (vb_eff < 4'd1) vb_eff = 4'd1;
		if (vb_eff > 4'(tlb_pkg::MaxVpnWidth)) vb_eff = 4'(tlb_pkg::MaxVpnWidth);
		tv_full = vaddr >> off_eff;
		sel_vpn = (mode == tlb_pkg::ModeTranslate) ? tv_full[7:0] : vpn;
		bad_range = (mode == tlb_pkg::ModeTranslate) ?
			((tv_full >> vb_eff) != 16'd0) : ((16'(vpn) >> vb_eff) != 16'd0);
		rd_addr = {pid, sel_vpn};
	end

	// Capture the word and start the page table read.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			pid_q <= pid;
			pfn_q <= pfn;
			vpn_q <= sel_vpn;
			ofs_q <= 8'(vaddr & ((16'd1 << off_eff) - 16'd1));
			slot_q <= tlb_slot;
			off_q <= off_eff;
			range_bad_q <= bad_range;
			pt_rd_q <= pt_mem[rd_addr];
		end
	end

	// Fully associative lookup on the captured tag.
	logic          hit;
	logic [SW-1:0] hit_idx, inv_idx, old_idx;
	logic          any_inv;
	always_comb begin
		hit = 1'b0;
		hit_idx = '0;
		any_inv = 1'b0;
		inv_idx = '0;
		old_idx = '0;
		for (int i = tlb_pkg::TlbEntries - 1; i >= 0; i--) begin
			if (valid_q[i] && owner_q[i] == pid_q && tag_q[i] == vpn_q) begin
				hit = 1'b1;
				hit_idx = SW'(i);
			end
			if (!valid_q[i]) begin
				any_inv = 1'b1;
				inv_idx = SW'(i);
			end
		end
		for (int i = 1; i < tlb_pkg::TlbEntries; i++)
			if (stamp_q[i] < stamp_q[old_idx]) old_idx = SW'(i);
	end

	logic [SW-1:0] map_idx;
	logic [15:0]   fr_tlb, fr_pt;
	assign map_idx = hit ? hit_idx : (any_inv ? inv_idx : old_idx);
	assign fr_tlb = (16'(frame_q[hit_idx]) << off_q) | 16'(ofs_q);
	assign fr_pt = (16'(pt_rd_q[7:0]) << off_q) | 16'(ofs_q);

	assign stat.clear_last = clr_q == AW'(tlb_pkg::PtDepth - 1);

	// Clearing pass and page table writes.
	always_ff @(posedge clk) begin
		if (cmd.clear_step) pt_mem[clr_q] <= 9'd0;
		else if (cmd.execute && !range_bad_q) begin
			if (mode_q == tlb_pkg::ModeMap) pt_mem[{pid_q, vpn_q}] <= {1'b1, pfn_q};
			else if (mode_q == tlb_pkg::ModeUnmap) pt_mem[{pid_q, vpn_q}] <= 9'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clear_step) clr_q <= clr_q + AW'(1);
	end

	// Execute: update TLB and tick, form the result word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			tick_q <= '0;
			for (int i = 0; i < tlb_pkg::TlbEntries; i++) begin
				tag_q[i] <= '0;
				frame_q[i] <= '0;
				owner_q[i] <= '0;
				stamp_q[i] <= '0;
			end
			status <= '0;
			phys_addr <= '0;
			hit_slot <= '0;
			entry_valid <= 1'b0;
			entry_vpn <= '0;
			entry_pfn <= '0;
			entry_pid <= '0;
			entry_time <= '0;
		end else if (cmd.execute) begin
			tick_q <= tick_q + 32'd1;
			status <= tlb_pkg::StatFault;
			phys_addr <= '0;
			hit_slot <= '0;
			entry_valid <= 1'b0;
			entry_vpn <= '0;
			entry_pfn <= '0;
			entry_pid <= '0;
			entry_time <= '0;
			case (mode_q)
				tlb_pkg::ModeTranslate: begin
					if (!range_bad_q) begin
						if (hit) begin
							if (lru_mode) stamp_q[hit_idx] <= tick_q + 32'd1;
							status <= tlb_pkg::StatDone;
							phys_addr <= fr_tlb;
							hit_slot <= 3'(hit_idx);
						end else if (pt_rd_q[8]) begin
							status <= tlb_pkg::StatPtHit;
							phys_addr <= fr_pt;
						end
					end
				end
				tlb_pkg::ModeMap: begin
					if (!range_bad_q) begin
						valid_q[map_idx] <= 1'b1;
						tag_q[map_idx] <= vpn_q;
						frame_q[map_idx] <= pfn_q;
						owner_q[map_idx] <= pid_q;
						stamp_q[map_idx] <= tick_q + 32'd1;
						hit_slot <= 3'(map_idx);
						status <= tlb_pkg::StatDone;
					end
				end
				tlb_pkg::ModeUnmap: begin
					if (!range_bad_q) begin
						if (hit) valid_q[hit_idx] <= 1'b0;
						status <= tlb_pkg::StatDone;
					end
				end
				tlb_pkg::ModePtRead: begin
					if (!range_bad_q) begin
						status <= tlb_pkg::StatDone;
						entry_valid <= pt_rd_q[8];
						entry_pfn <= pt_rd_q[8] ? pt_rd_q[7:0] : 8'd0;
					end
				end
				tlb_pkg::ModeTlbRead: begin
					status <= tlb_pkg::StatDone;
					entry_valid <= valid_q[slot_q];
					entry_vpn <= tag_q[slot_q];
					entry_pfn <= frame_q[slot_q];
					entry_pid <= owner_q[slot_q];
					entry_time <= stamp_q[slot_q];
				end
				default: status <= tlb_pkg::StatFault;
			endcase
		end
	end
endmodule

/* verif/tb_top.sv */
// Testbench for the TLB page translation unit: directed and random words checked
// against a behavioral TLB and page table model. Depends on hdl/tlb_pkg.sv.
`timescale 1ns / 1ps

// Holds the expected translation results and the mirror of TLB and page table state.
class tlb_scoreboard;
	typedef struct {
		logic [1:0] status;
		logic [15:0] phys_addr;
		logic [2:0] hit_slot;
		logic entry_valid;
		logic [7:0] entry_vpn;
		logic [7:0] entry_pfn;
		logic [1:0] entry_pid;
		logic [31:0] entry_time;
	} xlate_result_t;

	bit [3:0] offset_bits = 4;
	bit [3:0] page_bits = 4;
	bit lru_mode = 0;
	bit slot_valid[tlb_pkg::TlbEntries];
	bit [7:0] slot_vpn[tlb_pkg::TlbEntries];
	bit [7:0] slot_pfn[tlb_pkg::TlbEntries];
	bit [1:0] slot_pid[tlb_pkg::TlbEntries];
	bit [31:0] slot_stamp[tlb_pkg::TlbEntries];
	bit pt_valid[tlb_pkg::PtDepth];
	bit [7:0] pt_frame[tlb_pkg::PtDepth];
	bit [31:0] ticks = 0;
	xlate_result_t pending_results[$];
	int mismatches = 0;
	int checked = 0;

	function int find_slot(bit [1:0] p, bit [7:0] v);
		for (int i = 0; i < tlb_pkg::TlbEntries; i++)
			if (slot_valid[i] && slot_pid[i] == p && slot_vpn[i] == v) return i;
		return -1;
	endfunction

	function int pick_victim();
		int best;
		best = 0;
		for (int i = 0; i < tlb_pkg::TlbEntries; i++)
			if (!slot_valid[i]) return i;
		for (int i = 1; i < tlb_pkg::TlbEntries; i++)
			if (slot_stamp[i] < slot_stamp[best]) best = i;
		return best;
	endfunction

	// Work out the result of one accepted input word and update the mirror.
	function void note_word(bit [2:0] md, bit [1:0] p, bit [15:0] va, bit [7:0] vp,
			bit [7:0] pf, bit [2:0] sl);
		xlate_result_t r;
		int off, nbits, h, idx;
		bit [15:0] page, ofs;
		r = '{default: 0};
		off = (offset_bits > tlb_pkg::MaxOffsetWidth) ? tlb_pkg::MaxOffsetWidth : offset_bits;
		nbits = (page_bits < 1) ? 1 : (page_bits > tlb_pkg::MaxVpnWidth) ?
			tlb_pkg::MaxVpnWidth : page_bits;
		ticks++;
		case (md)
			tlb_pkg::ModeTranslate: begin
				page = va >> off;
				ofs = 16'(va & ((16'd1 << off) - 1));
				if (page >= (1 << nbits)) begin
					r.status = tlb_pkg::StatFault;
				end else begin
					h = find_slot(p, page[7:0]);
					idx = p * 256 + page;
					if (h >= 0) begin
						if (lru_mode) slot_stamp[h] = ticks;
						r.status = tlb_pkg::StatDone;
						r.phys_addr = 16'((32'(slot_pfn[h]) << off) | ofs);
						r.hit_slot = 3'(h);
					end else if (pt_valid[idx]) begin
						r.status = tlb_pkg::StatPtHit;
						r.phys_addr = 16'((32'(pt_frame[idx]) << off) | ofs);
					end else begin
						r.status = tlb_pkg::StatFault;
					end
				end
			end
			tlb_pkg::ModeMap, tlb_pkg::ModeUnmap, tlb_pkg::ModePtRead: begin
				idx = p * 256 + vp;
				if (vp >= (1 << nbits)) begin
					r.status = tlb_pkg::StatFault;
				end else begin
					r.status = tlb_pkg::StatDone;
					if (md == tlb_pkg::ModeMap) begin
						pt_valid[idx] = 1;
						pt_frame[idx] = pf;
						h = find_slot(p, vp);
						if (h < 0) h = pick_victim();
						slot_valid[h] = 1;
						slot_vpn[h] = vp;
						slot_pfn[h] = pf;
						slot_pid[h] = p;
						slot_stamp[h] = ticks;
						r.hit_slot = 3'(h);
					end else if (md == tlb_pkg::ModeUnmap) begin
						pt_valid[idx] = 0;
						pt_frame[idx] = 0;
						h = find_slot(p, vp);
						if (h >= 0) slot_valid[h] = 0;
					end else begin
						r.entry_valid = pt_valid[idx];
						r.entry_pfn = pt_valid[idx] ? pt_frame[idx] : 8'd0;
					end
				end
			end
			tlb_pkg::ModeTlbRead: begin
				r.status = tlb_pkg::StatDone;
				r.entry_valid = slot_valid[sl];
				r.entry_vpn = slot_vpn[sl];
				r.entry_pfn = slot_pfn[sl];
				r.entry_pid = slot_pid[sl];
				r.entry_time = slot_stamp[sl];
			end
			default: r.status = tlb_pkg::StatFault;
		endcase
		pending_results.push_back(r);
	endfunction

	// Compare one accepted result word with the oldest expectation.
	function void check_result(xlate_result_t got);
		xlate_result_t want;
		checked++;
		if (pending_results.size() == 0) begin
			report("result word with nothing expected");
			return;
		end
		want = pending_results.pop_front();
		if (got.status !== want.status) report($sformatf("status %0d want %0d",
			got.status, want.status));
		if (got.phys_addr !== want.phys_addr) report($sformatf("phys_addr %h want %h",
			got.phys_addr, want.phys_addr));
		if (got.hit_slot !== want.hit_slot) report($sformatf("hit_slot %0d want %0d",
			got.hit_slot, want.hit_slot));
		if (got.entry_valid !== want.entry_valid) report($sformatf("entry_valid %0d want %0d",
			got.entry_valid, want.entry_valid));
		if (got.entry_vpn !== want.entry_vpn) report($sformatf("entry_vpn %h want %h",
			got.entry_vpn, want.entry_vpn));
		if (got.entry_pfn !== want.entry_pfn) report($sformatf("entry_pfn %h want %h",
			got.entry_pfn, want.entry_pfn));
		if (got.entry_pid !== want.entry_pid) report($sformatf("entry_pid %0d want %0d",
			got.entry_pid, want.entry_pid));
		if (got.entry_time !== want.entry_time) report($sformatf("entry_time %0d want %0d",
			got.entry_time, want.entry_time));
	endfunction

	// Count one mismatch and print its line for the first 50.
	function void report(string msg);
		mismatches++;
		if (mismatches <= 50) $display("[%0t] mismatch on word %0d: %s", $time, checked, msg);
	endfunction
endclass

module tb_top;
	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 0;
	logic in_stall;
	logic [2:0] mode = 0;
	logic [1:0] pid = 0;
	logic [15:0] vaddr = 0;
	logic [7:0] vpn = 0, pfn = 0;
	logic [2:0] tlb_slot = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [1:0] status;
	logic [15:0] phys_addr;
	logic [2:0] hit_slot;
	logic entry_valid;
	logic [7:0] entry_vpn, entry_pfn;
	logic [1:0] entry_pid;
	logic [31:0] entry_time;

	tlb_scoreboard sb = new();
	int words_sent = 0;
	bit stall_quiet = 0;
	bit stall_burst = 0;

	tlb_page_translation_unit uut (.*);

	always #6 clk = ~clk;

	// Limit on the whole run.
	initial begin
		#20ms;
		$display("FAIL tlb_page_translation_unit");
		$finish;
	end

	// Receive side: random stall, check each accepted result word.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{status, phys_addr, hit_slot, entry_valid, entry_vpn,
				entry_pfn, entry_pid, entry_time});
		if (stall_burst) out_stall <= 1;
		else if (stall_quiet || $urandom_range(0, 3) != 0) out_stall <= 0;
		else out_stall <= ($urandom_range(0, 9) == 0) ? 1 : ($urandom_range(0, 1) == 0);
	end

	// Quiet spells and long stall bursts now and then.
	initial begin
		forever begin
			repeat ($urandom_range(50, 400)) @(posedge clk);
			stall_quiet = ($urandom_range(0, 2) == 0);
			if ($urandom_range(0, 3) == 0) begin
				stall_burst = 1;
				repeat ($urandom_range(10, 40)) @(posedge clk);
				stall_burst = 0;
			end
		end
	end

	// Write one configuration register through the setup and access cycles.
	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			tlb_pkg::RegOffset: sb.offset_bits = value[3:0];
			tlb_pkg::RegVpn: sb.page_bits = value[3:0];
			default: sb.lru_mode = value[0];
		endcase
	endtask

	// Send one word, with a random gap before it.
	task automatic send_word(logic [2:0] md, logic [1:0] p, logic [15:0] va,
			logic [7:0] vp, logic [7:0] pf, logic [2:0] sl);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) gap = 0;
		repeat (gap) begin
			@(posedge clk);
			in_valid <= 0;
		end
		@(posedge clk);
		in_valid <= 1;
		mode <= md;
		pid <= p;
		vaddr <= va;
		vpn <= vp;
		pfn <= pf;
		tlb_slot <= sl;
		do @(posedge clk); while (in_stall);
		sb.note_word(md, p, va, vp, pf, sl);
		words_sent++;
		in_valid <= 0;
	endtask

	// Wait until every expected result word has been checked, then idle before going on.
	task automatic drain();
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Random word biased toward pages that are in range for the current setting.
	task automatic random_word();
		logic [2:0] md;
		logic [7:0] vp;
		int nb, off;
		off = (sb.offset_bits > 8) ? 8 : sb.offset_bits;
		nb = (sb.page_bits < 1) ? 1 : (sb.page_bits > 8) ? 8 : sb.page_bits;
		md = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
		if (md == tlb_pkg::ModeTranslate && $urandom_range(0, 2) != 0)
			md = tlb_pkg::ModeTranslate;
		vp = ($urandom_range(0, 7) == 0) ? 8'($urandom) :
			8'($urandom_range(0, (1 << nb) - 1) & ($urandom_range(0, 1) ? 8'h0f : 8'hff));
		if (vp >= (1 << nb) && $urandom_range(0, 1)) vp = vp % (1 << nb);
		send_word(md, $urandom_range(0, 3),
			($urandom_range(0, 7) == 0) ? 16'($urandom) :
				16'((32'(vp) << off) | ($urandom & ((1 << off) - 1))),
			vp, 8'($urandom), $urandom_range(0, 7));
	endtask

	initial begin
		int unsigned settings[6][3];
		settings = '{'{4, 4, 0}, '{0, 1, 1}, '{8, 8, 0}, '{15, 0, 1}, '{2, 3, 1}, '{9, 15, 0}};
		repeat (11) @(posedge clk);
		arst_n <= 1;

		// Directed: extremes, every mode, faults, eviction and slot reads.
		send_word(tlb_pkg::ModePtRead, 3, 0, 8'd15, 0, 0);
		send_word(tlb_pkg::ModeTranslate, 0, 16'h0000, 0, 0, 0);
		send_word(tlb_pkg::ModeMap, 0, 0, 8'd0, 8'hff, 0);
		send_word(tlb_pkg::ModeTranslate, 0, 16'h000f, 0, 0, 0);
		for (int i = 0; i < 10; i++)
			send_word(tlb_pkg::ModeMap, 2'(i % 4), 0, 8'(i), 8'(i * 29), 0);
		send_word(tlb_pkg::ModeMap, 3, 0, 8'd16, 8'h55, 0);
		send_word(tlb_pkg::ModeTranslate, 1, 16'hffff, 0, 0, 0);
		send_word(tlb_pkg::ModeTranslate, 1, 16'h001a, 0, 0, 0);
		send_word(tlb_pkg::ModePtRead, 0, 0, 8'd0, 0, 0);
		send_word(tlb_pkg::ModeUnmap, 1, 0, 8'd1, 0, 0);
		send_word(tlb_pkg::ModeTranslate, 1, 16'h0013, 0, 0, 0);
		send_word(tlb_pkg::ModeTlbRead, 0, 0, 0, 0, 3'd7);
		send_word(tlb_pkg::ModeTlbRead, 0, 0, 0, 0, 3'd0);
		send_word(3'd7, 2, 16'hffff, 8'hff, 8'hff, 3'd7);
		send_word(3'd5, 0, 0, 0, 0, 0);
		drain();

		// Random phases over several register settings.
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(tlb_pkg::RegOffset, settings[ph][0]);
			write_reg(tlb_pkg::RegVpn, settings[ph][1]);
			write_reg(tlb_pkg::RegLru, settings[ph][2]);
			repeat (85) random_word();
			drain();
		end

		$display("Sent %0d words over six register settings, %0d result words checked.",
			words_sent, sb.checked);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
			$display("PASS tlb_page_translation_unit");
		end else begin
			$display("FAIL tlb_page_translation_unit");
		end
		$finish;
	end
endmodule

/* files.f */
hdl/tlb_pkg.sv
hdl/tlb_ctrl.sv
hdl/tlb_dp.sv
hdl/tlb_page_translation_unit.sv
verif/tb_top.sv
